### rtl/core/assert_macros.svh
// Assertion macros shared by the sliding window maximum RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge, masked while reset is high.
`define SWM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// Same-cycle implication.
`define SWM_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define SWM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/swm_pkg.sv
// Shared constants, types and helpers of the sliding window maximum.
package swm_pkg;

   localparam int unsigned WINDOW_MAX = 64;
   localparam int unsigned DATA_W     = 32;
   localparam int unsigned LEN_W      = 7;
   // window length, age and fill count all stay within 0..WINDOW_MAX
   localparam int unsigned KW         = $clog2(WINDOW_MAX + 1);

   typedef struct packed {
      logic                     valid;
      logic signed [DATA_W-1:0] value;
      logic        [KW-1:0]     age;    // age the candidate will have at the next beat
   } swm_cand_type;

   typedef struct packed {
      logic                     step;     // beat accepted this cycle
      logic                     trim;     // drop the front candidate, no beat
      logic                     shift;    // front candidate leaves during this beat
      logic                     restart;
      logic signed [DATA_W-1:0] sample;
   } swm_ctrl_type;

   function automatic logic [KW-1:0] eff_len(input logic [LEN_W-1:0] wl);
      logic [KW-1:0] res;
      if (wl == '0) begin
         res = KW'(1);
      end else if (32'(wl) > WINDOW_MAX) begin
         res = KW'(WINDOW_MAX);
      end else begin
         res = KW'(wl);
      end
      return res;
   endfunction

endpackage

### rtl/core/swm_cell.sv
// One candidate cell of the monotonic queue chain.
module swm_cell import swm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  swm_ctrl_type  ctrl,
   input  logic [KW-1:0] win_len,
   input  swm_cand_type  right_cand,
   input  logic          right_keep,
   input  logic          left_bnd,
   output swm_cand_type  cand,
   output logic          keep,
   output logic          bnd,
   output logic          expired
);

   swm_cand_type cand_ff, cand_in;
   swm_cand_type src;
   logic         src_keep;
   logic         left_ok;
   logic         greater;

   assign cand    = cand_ff;
   assign expired = cand_ff.valid & (cand_ff.age >= win_len);
   assign greater = $signed(cand_ff.value) > $signed(ctrl.sample);
   assign keep    = cand_ff.valid & ~ctrl.restart & ~expired & greater;
   // expired cells sit at the front, so they bound the survivors too;
   // a restart leaves no bound at all
   assign bnd     = keep | (expired & ~ctrl.restart);

   always_comb begin
      src      = ctrl.shift ? right_cand : cand_ff;
      src_keep = ctrl.shift ? right_keep : keep;
      left_ok  = ctrl.shift ? bnd : left_bnd;
      cand_in  = cand_ff;
      if (ctrl.trim) begin
         cand_in = right_cand;
      end else if (ctrl.step) begin
         if (src_keep) begin
            cand_in     = src;
            cand_in.age = src.age + KW'(1);
         end else if (left_ok) begin
            cand_in.valid = 1'b1;
            cand_in.value = ctrl.sample;
            cand_in.age   = KW'(1);
         end else begin
            cand_in.valid = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cand_ff.valid <= 1'b0;
      end else begin
         cand_ff <= cand_in;
      end
   end

endmodule

### rtl/core/swm_out_buf.sv
// Two-entry result buffer: presented register plus skid register.
module swm_out_buf import swm_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  logic signed [DATA_W-1:0] push_data,
   output logic                     full,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_window_max
);

   logic                     a_valid_ff, a_valid_in;
   logic                     b_valid_ff, b_valid_in;
   logic signed [DATA_W-1:0] a_data_ff, a_data_in;
   logic signed [DATA_W-1:0] b_data_ff, b_data_in;

   assign full           = b_valid_ff;
   assign rsp_valid      = a_valid_ff;
   assign rsp_window_max = a_data_ff;

   always_comb begin
      a_valid_in = a_valid_ff;
      a_data_in  = a_data_ff;
      b_valid_in = b_valid_ff;
      b_data_in  = b_data_ff;
      if (a_valid_ff && !rsp_stall) begin
         a_valid_in = b_valid_ff;
         a_data_in  = b_data_ff;
         b_valid_in = 1'b0;
      end
      // push only arrives while the skid entry is free
      if (push) begin
         if (!a_valid_in) begin
            a_valid_in = 1'b1;
            a_data_in  = push_data;
         end else begin
            b_valid_in = 1'b1;
            b_data_in  = push_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
      a_data_ff <= a_data_in;
      b_data_ff <= b_data_in;
   end

endmodule

### rtl/core/sliding_window_maximum.sv
// Top level of the sliding window maximum over signed 32-bit samples.
//
// Running maximum of the last window_length samples (1..64; zero reads as 1,
// larger values as 64). Candidates live in a chain of 64 cells, front (the
// current maximum) in cell 0, values strictly falling towards the back. Each
// beat compares the sample against every cell at once: cells not greater
// than the sample drop out, the sample lands just behind the last survivor,
// and an expired front candidate leaves by shifting the chain one cell left.
// One beat is taken per clock while req_stall is low. Lowering window_length
// makes each further expired front candidate shift the chain left with
// req_stall high, no beat taken; these shifts run straight after the write,
// whether or not a beat is waiting. A result is produced for every beat once
// window_length samples of the current sequence have arrived; req_restart
// starts a new sequence with its own beat. Results pass through a two-entry
// buffer, so input beats keep flowing while one result waits on rsp_stall.
`include "assert_macros.svh"

module sliding_window_maximum import swm_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   // sample channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [DATA_W-1:0] req_sample,
   input  logic                     req_restart,
   // result channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_window_max,
   // configuration
   input  logic                     csr_write_enable,
   input  logic        [LEN_W-1:0]  csr_write_data
);

   logic [LEN_W-1:0] window_length_ff;
   logic [KW-1:0]    win_len;
   logic [KW-1:0]    fill_ff, fill_in;

   swm_ctrl_type     ctrl;
   swm_cand_type     cand    [WINDOW_MAX];
   logic             keep    [WINDOW_MAX];
   logic             bnd     [WINDOW_MAX];
   logic             expired [WINDOW_MAX];
   logic [WINDOW_MAX-1:0] valid_vec, valid_inc;

   logic                     buf_full;
   logic                     trim;
   logic                     step;
   logic                     has_result;
   logic signed [DATA_W-1:0] front_value;
   logic                     front_pair;
   logic                     front_desc;

   assign win_len = eff_len(window_length_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= LEN_W'(1);
      end else if (csr_write_enable) begin
         window_length_ff <= csr_write_data;
      end
   end

   // Two expired fronts means the window shrank: shift them out first.
   assign trim      = expired[0] & expired[1];
   assign req_stall = buf_full | trim;
   assign step      = req_valid & ~req_stall;

   assign ctrl.step    = step;
   assign ctrl.trim    = trim;
   assign ctrl.restart = req_restart;
   assign ctrl.shift   = ~req_restart & expired[0];
   assign ctrl.sample  = req_sample;

   // Cell chain
   for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
      swm_cand_type right_cand;
      logic         right_keep;
      logic         left_bnd;

      if (i == WINDOW_MAX - 1) begin : g_last
         assign right_cand = '0;
         assign right_keep = 1'b0;
      end else begin : g_mid
         assign right_cand = cand[i+1];
         assign right_keep = keep[i+1];
      end

      if (i == 0) begin : g_front
         assign left_bnd = 1'b1;
      end else begin : g_rest
         assign left_bnd = bnd[i-1];
      end

      swm_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .win_len    (win_len),
         .right_cand (right_cand),
         .right_keep (right_keep),
         .left_bnd   (left_bnd),
         .cand       (cand[i]),
         .keep       (keep[i]),
         .bnd        (bnd[i]),
         .expired    (expired[i])
      );

      assign valid_vec[i] = cand[i].valid;
   end

   // Front after this beat: first survivor, else the sample itself.
   always_comb begin
      if (ctrl.shift) begin
         front_value = keep[1] ? cand[1].value : req_sample;
      end else begin
         front_value = keep[0] ? cand[0].value : req_sample;
      end
   end

   // Samples seen in this sequence, saturating at the chain length.
   always_comb begin
      if (req_restart) begin
         fill_in = KW'(1);
      end else if (fill_ff == KW'(WINDOW_MAX)) begin
         fill_in = fill_ff;
      end else begin
         fill_in = fill_ff + KW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (step) begin
         fill_ff <= fill_in;
      end
   end

   assign has_result = step & (fill_in >= win_len);

   swm_out_buf u_out_buf (
      .clock          (clock),
      .reset          (reset),
      .push           (has_result),
      .push_data      (front_value),
      .full           (buf_full),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_window_max (rsp_window_max)
   );

   // Checks
   assign valid_inc  = valid_vec + WINDOW_MAX'(1);
   assign front_pair = cand[0].valid & cand[1].valid;
   assign front_desc = $signed(cand[0].value) > $signed(cand[1].value);

   `SWM_ASSERT(a_queue_packed, (valid_inc & valid_vec) == '0, "candidate gap in chain")
   `SWM_ASSERT_IMPLY(a_queue_order, front_pair, front_desc, "candidates out of order")
   `SWM_ASSERT_NEXT(a_result_shown, has_result, rsp_valid, "result not presented")

endmodule

### bench/swm_window_tracker.sv
// Scoreboard package: tracks the sliding window maximum and checks results.
`timescale 1ns / 100ps

package swm_bench_pkg;
   import swm_pkg::*;

   class swm_window_tracker;
      typedef struct {
         logic signed [DATA_W-1:0] value;
         logic        [LEN_W-1:0]  pos;
      } cand_type;

      logic [LEN_W-1:0]         length;      // window length register as written
      cand_type                 cands[$];    // values strictly falling front to back
      logic [LEN_W-1:0]         next_pos;
      int unsigned              filled;      // saturates at WINDOW_MAX
      logic signed [DATA_W-1:0] pending_max[$];
      int                       failures;

      function new();
         length   = LEN_W'(1);
         next_pos = '0;
         filled   = 0;
         failures = 0;
      endfunction

      function void set_length(logic [LEN_W-1:0] len);
         length = len;
      endfunction

      function int unsigned span();
         if (length == 0) return 1;
         if (length > WINDOW_MAX) return WINDOW_MAX;
         return length;
      endfunction

      function int pending_count();
         return pending_max.size();
      endfunction

      function void note_sample(logic signed [DATA_W-1:0] sample, logic restart);
         int unsigned      k;
         logic [LEN_W-1:0] age;
         cand_type         joined;
         k = span();
         if (restart) begin
            cands.delete();
            next_pos = '0;
            filled   = 0;
         end
         // expire from the front; ages are modulo the position width
         while (cands.size() > 0) begin
            age = next_pos - cands[0].pos;
            if (age < k) break;
            cands.delete(0);
         end
         // equal values go too
         while (cands.size() > 0 && cands[$].value <= sample) cands.delete(cands.size() - 1);
         if (cands.size() < WINDOW_MAX) begin
            joined.value = sample;
            joined.pos   = next_pos;
            cands.insert(cands.size(), joined);
         end
         next_pos++;
         if (filled < WINDOW_MAX) filled++;
         if (filled >= k) pending_max.insert(pending_max.size(), cands[0].value);
      endfunction

      function void check_max(logic signed [DATA_W-1:0] actual);
         logic signed [DATA_W-1:0] want;
         if (pending_max.size() == 0) begin
            $display("%0t: window_max expected none, got %0d", $time, actual);
            failures++;
            return;
         end
         want = pending_max[0];
         pending_max.delete(0);
         if (actual !== want) begin
            $display("%0t: window_max expected %0d, got %0d", $time, want, actual);
            failures++;
         end
      endfunction
   endclass

endpackage

### bench/tb.sv
// Top-level testbench of the sliding window maximum.
`timescale 1ns / 100ps

module tb;
   import swm_pkg::*;
   import swm_bench_pkg::*;

   // Random part length, quiet-cycle limit of the watchdog, and the settle time
   // given to a beat that causes no result before the window length is rewritten.
   localparam int ITEM_TARGET   = 1650;
   localparam int QUIET_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 8;

   localparam logic signed [DATA_W-1:0] S_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] S_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   // shape of the sample values within one phase
   typedef enum int {
      STYLE_RANDOM,
      STYLE_NARROW,
      STYLE_FALLING,
      STYLE_RISING,
      STYLE_EXTREME
   } sample_style_type;

   logic                     clock            = 1'b0;
   logic                     reset            = 1'b1;
   logic                     req_valid        = 1'b0;
   logic                     req_stall;
   logic signed [DATA_W-1:0] req_sample       = '0;
   logic                     req_restart      = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall        = 1'b0;
   logic signed [DATA_W-1:0] rsp_window_max;
   logic                     csr_write_enable = 1'b0;
   logic        [LEN_W-1:0]  csr_write_data   = '0;

   // pacing of either side: 0 never idles, 1 idles now and then, 2 idles often
   int                       tx_mode  = 0;
   int                       rsp_mode = 1;
   logic signed [DATA_W-1:0] trend    = '0;

   swm_window_tracker sb;

   wire sample_beat = req_valid && !req_stall;
   wire result_beat = rsp_valid && !rsp_stall;

   sliding_window_maximum dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample       (req_sample),
      .req_restart      (req_restart),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_window_max   (rsp_window_max),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Everything the block takes or gives is seen here, at the rising edge,
   // so the model follows the block beat for beat. Length writes go in
   // before the beat of the same edge, though they never share one.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_write_enable) sb.set_length(csr_write_data);
         if (sample_beat) sb.note_sample(req_sample, req_restart);
         if (result_beat) sb.check_max(rsp_window_max);
      end
   end

   // Watchdog: ends the run after too many cycles with no beat on either side.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || sample_beat || result_beat) quiet = 0;
         else quiet++;
      end
      $display("FAIL sliding_window_maximum");
      $finish;
   end

   // mostly short idles, a few long ones
   function automatic int idle_len();
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int sender_gap();
      case (tx_mode)
         0: begin
            return 0;
         end
         1: begin
            return ($urandom_range(0, 99) < 15) ? idle_len() : 0;
         end
         default: begin
            return ($urandom_range(0, 99) < 50) ? idle_len() : 0;
         end
      endcase
   endfunction

   // Window length for a phase: mostly small, with the extremes and the
   // out-of-range codes (zero, above the maximum) drawn regularly.
   function automatic logic [LEN_W-1:0] pick_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return '0;
      if (r < 20) return LEN_W'(1);
      if (r < 32) return LEN_W'(WINDOW_MAX);
      if (r < 35) return '1;
      if (r < 40) return LEN_W'($urandom_range(WINDOW_MAX + 1, 126));
      if (r < 50) return LEN_W'($urandom_range(9, WINDOW_MAX - 1));
      return LEN_W'($urandom_range(2, 8));
   endfunction

   // Falling runs build a deep candidate queue, narrow values give many ties,
   // rising runs keep it one deep.
   function automatic logic signed [DATA_W-1:0] draw_sample(sample_style_type style);
      int r;
      r = $urandom_range(0, 19);
      case (style)
         STYLE_NARROW: begin
            return $signed($urandom_range(0, 16)) - 8;
         end
         STYLE_FALLING: begin
            if (r == 0) return $urandom;
            trend = trend - $signed($urandom_range(0, 3));
            return trend;
         end
         STYLE_RISING: begin
            if (r == 0) return $urandom;
            trend = trend + $signed($urandom_range(0, 3));
            return trend;
         end
         STYLE_EXTREME: begin
            if (r < 5) return S_MAX;
            if (r < 10) return S_MIN;
            if (r < 13) return '0;
            if (r < 16) return '1;
            return $urandom;
         end
         default: begin
            return $urandom;
         end
      endcase
   endfunction

   // One beat; called and returning at a falling edge. Valid is only lowered
   // when a gap is wanted, so back-to-back beats keep it high.
   task automatic send_sample(input logic signed [DATA_W-1:0] sample, input logic restart,
                              input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_sample  <= sample;
      req_restart <= restart;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Hold off the sender until every expected result is out, then let any
   // beat with no result settle.
   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (sb.pending_count() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_length(input logic [LEN_W-1:0] len);
      csr_write_data   <= len;
      csr_write_enable <= 1'b1;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Result side stalls in runs; mode 0 gives stretches with no stall at all.
   initial begin : result_pacing
      int hold;
      hold = 0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            hold--;
         end else if (rsp_mode == 0 || rsp_stall) begin
            rsp_stall <= 1'b0;
            hold = (rsp_mode == 2) ? $urandom_range(0, 4) : $urandom_range(0, 12);
         end else if ($urandom_range(0, 99) < ((rsp_mode == 2) ? 60 : 20)) begin
            rsp_stall <= 1'b1;
            hold = idle_len() - 1;
         end
      end
   end

   initial begin : stimulus
      int               sent;
      int               k;
      int               phase_len;
      bit               fresh;
      logic [LEN_W-1:0] len;
      sample_style_type style;

      sb = new();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed. Window of one after reset: every beat echoes, extremes first.
      send_sample(S_MAX, 1'b1, 0);
      send_sample(S_MIN, 1'b0, 0);
      send_sample('0, 1'b0, 0);
      send_sample('1, 1'b0, 0);
      drain();

      // Window of three: ties, the minimum repeated, the maximum taking over.
      write_length(LEN_W'(3));
      send_sample(32'sd5, 1'b1, 0);
      send_sample(32'sd5, 1'b0, 0);
      send_sample(32'sd5, 1'b0, 0);
      send_sample(32'sd7, 1'b0, 0);
      send_sample(S_MIN, 1'b0, 0);
      send_sample(S_MIN, 1'b0, 0);
      send_sample(S_MIN, 1'b0, 0);
      send_sample(S_MAX, 1'b0, 0);
      send_sample(32'sd1, 1'b0, 0);
      send_sample(32'sd2, 1'b0, 0);
      drain();

      // Length zero reads as one; lowering it mid-sequence expires the maximum.
      write_length('0);
      send_sample(-32'sd3, 1'b0, 0);
      send_sample(32'sd4, 1'b0, 0);
      drain();

      // Falling run stacks candidates, then a restart empties them.
      write_length(LEN_W'(2));
      send_sample(-32'sd1, 1'b1, 0);
      send_sample(-32'sd2, 1'b0, 0);
      send_sample(-32'sd3, 1'b0, 0);
      send_sample(-32'sd4, 1'b0, 0);
      send_sample(32'sd9, 1'b1, 0);

      // Random phases. Each starts idle with a new length; a quarter of them
      // carry the old sequence on, so the length changes mid-sequence.
      sent = 0;
      while (sent < ITEM_TARGET) begin
         drain();
         len = pick_length();
         write_length(len);
         k         = (len == 0) ? 1 : ((len > WINDOW_MAX) ? WINDOW_MAX : int'(len));
         phase_len = $urandom_range(k + 4, 2 * k + 40);
         fresh     = ($urandom_range(0, 99) < 75);
         tx_mode   = $urandom_range(0, 2);
         rsp_mode  = $urandom_range(0, 2);
         style     = sample_style_type'($urandom_range(0, 4));
         trend     = $urandom;
         for (int i = 0; i < phase_len; i++) begin
            send_sample(draw_sample(style), (i == 0 && fresh) || ($urandom_range(0, 99) == 0),
                        sender_gap());
            sent++;
         end
      end
      drain();

      if (sb.failures == 0 && sb.pending_count() == 0) begin
         $display("PASS sliding_window_maximum");
      end else begin
         $display("FAIL sliding_window_maximum");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/swm_pkg.sv
rtl/core/swm_cell.sv
rtl/core/swm_out_buf.sv
rtl/core/sliding_window_maximum.sv
bench/swm_window_tracker.sv
bench/tb.sv
